/* rtl/core/tfc_pkg.sv */
package tfc_pkg;

    localparam int IN_W        = 104;
    localparam int OUT_W       = 216;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int FRAME_BITS  = 88;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0]  RESET_MAX_ROLE   = 8'd1;
    localparam logic [7:0]  RESET_MAX_CTRL   = 8'd7;
    localparam logic [7:0]  RESET_MAX_ABORT  = 8'd1;
    localparam logic [15:0] RESET_POWER_THR  = 16'd10;
    localparam logic [15:0] RUN_MAX          = 16'hFFFF;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT = 2'd0,
        VERDICT_CRC    = 2'd1,
        VERDICT_RANGE  = 2'd2
    } verdict_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAX_ROLE   = 8'd0,
        REG_MAX_CTRL   = 8'd1,
        REG_MAX_ABORT  = 8'd2,
        REG_POWER_THR  = 8'd3
    } cfg_reg_t;

    // Input frame, first field in the highest bits.
    typedef struct packed {
        logic [15:0]        received_check;
        logic [15:0]        frame_sequence;
        logic [7:0]         abort_code;
        logic signed [15:0] coil_error_word;
        logic signed [15:0] power_level;
        logic [7:0]         control_state_code;
        logic [7:0]         role_code;
        logic signed [15:0] energy_word;
    } frame_t;

    typedef logic [FRAME_BITS-1:0][15:0] crc_cols_t;

    // Bit-serial CRC, MSB of the message first. Used only to build constants.
    function automatic logic [15:0] crc_serial(input logic [FRAME_BITS-1:0] msg,
                                               input logic [15:0] seed);
        logic [15:0] crc;
        logic        fb;
        crc = seed;
        for (int i = FRAME_BITS - 1; i >= 0; i--)
        begin
            fb  = crc[15] ^ msg[i];
            crc = {crc[14:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    // The CRC is linear in the message bits: each bit contributes one column.
    function automatic crc_cols_t crc_columns();
        crc_cols_t                cols;
        logic [FRAME_BITS-1:0]    one_hot;
        for (int i = 0; i < FRAME_BITS; i++)
        begin
            one_hot = {{(FRAME_BITS-1){1'b0}}, 1'b1} << i;
            cols[i] = crc_serial(one_hot, 16'h0000);
        end
        return cols;
    endfunction

    localparam crc_cols_t   CRC_COLS = crc_columns();
    localparam logic [15:0] CRC_BASE = crc_serial({FRAME_BITS{1'b0}}, CRC_INIT);

endpackage

/* rtl/core/telemetry_frame_checker.sv */
// A result is registered from the input register into the result register; an output stall holds it back.
// One frame per cycle unless the output stalls; the CRC is a combinational XOR tree over the 88 covered bits.
// The input side keeps accepting while a result waits, as long as the input register can move on.
// Configuration writes are always ready and take effect on the next cycle.
// Reset clears all counters, sequence and power tracking, and returns the limits to defaults.
module telemetry_frame_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // energy_word, role_code, control_state_code, power_level, coil_error_word,
    // abort_code, frame_sequence, received_check
    input  logic [tfc_pkg::IN_W-1:0]             s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // verdict, sequence_step, sequence_gap, power_drop_latched, power_drop_sequence,
    // power_drop_step, invalid_run, invalid_run_peak, accepted_total, invalid_total,
    // crc_error_total, gap_total, zero pad
    output logic [tfc_pkg::OUT_W-1:0]            m_axis_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tfc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tfc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import tfc_pkg::*;

    logic [7:0]         max_role_reg;
    logic [7:0]         max_ctrl_reg;
    logic [7:0]         max_abort_reg;
    logic signed [15:0] power_thr_reg;

    logic               in_valid_reg;
    frame_t             frame_reg;
    logic               out_valid_reg;
    logic               advance;

    verdict_t           verdict_reg,      verdict_next;
    logic [15:0]        step_reg,         step_next;
    logic               gap_reg,          gap_next;
    logic [15:0]        prev_seq_reg,     prev_seq_next;
    logic               seq_seen_reg,     seq_seen_next;
    logic               power_seen_reg,   power_seen_next;
    logic               drop_latch_reg,   drop_latch_next;
    logic [15:0]        drop_seq_reg,     drop_seq_next;
    logic [15:0]        drop_step_reg,    drop_step_next;
    logic [15:0]        run_reg,          run_next;
    logic [15:0]        peak_reg,         peak_next;
    logic [31:0]        accepted_reg,     accepted_next;
    logic [31:0]        invalid_reg,      invalid_next;
    logic [31:0]        crc_fail_reg,     crc_fail_next;
    logic [31:0]        gap_count_reg,    gap_count_next;

    logic [FRAME_BITS-1:0] crc_msg;
    logic [15:0]           crc_calc;
    logic                  crc_ok;
    logic                  range_bad;
    logic                  invalid;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_role_reg  <= RESET_MAX_ROLE;
            max_ctrl_reg  <= RESET_MAX_CTRL;
            max_abort_reg <= RESET_MAX_ABORT;
            power_thr_reg <= RESET_POWER_THR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAX_ROLE:  max_role_reg  <= cfg_data[7:0];
                REG_MAX_CTRL:  max_ctrl_reg  <= cfg_data[7:0];
                REG_MAX_ABORT: max_abort_reg <= cfg_data[7:0];
                REG_POWER_THR: power_thr_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            frame_reg <= frame_t'(s_axis_tdata);
        end
    end

    // CRC over the 11 covered bytes, high byte of each word first.
    assign crc_msg = {frame_reg.energy_word, frame_reg.role_code, frame_reg.control_state_code,
                      frame_reg.power_level, frame_reg.coil_error_word, frame_reg.abort_code,
                      frame_reg.frame_sequence};

    always_comb
    begin
        crc_calc = CRC_BASE;
        for (int i = 0; i < FRAME_BITS; i++)
        begin
            if (crc_msg[i])
            begin
                crc_calc = crc_calc ^ CRC_COLS[i];
            end
        end
    end

    assign crc_ok    = (crc_calc == frame_reg.received_check);
    assign range_bad = (frame_reg.role_code > max_role_reg)
                    || (frame_reg.control_state_code > max_ctrl_reg)
                    || (frame_reg.abort_code > max_abort_reg);
    assign invalid   = !crc_ok || range_bad;

    always_comb
    begin
        step_next       = 16'd0;
        gap_next        = 1'b0;
        prev_seq_next   = prev_seq_reg;
        seq_seen_next   = seq_seen_reg;
        power_seen_next = power_seen_reg;
        drop_latch_next = drop_latch_reg;
        drop_seq_next   = drop_seq_reg;
        drop_step_next  = drop_step_reg;
        accepted_next   = accepted_reg;
        invalid_next    = invalid_reg;
        crc_fail_next   = crc_fail_reg;
        gap_count_next  = gap_count_reg;
        run_next        = run_reg;
        peak_next       = peak_reg;

        if (crc_ok)
        begin
            if (seq_seen_reg)
            begin
                step_next = frame_reg.frame_sequence - prev_seq_reg;
                gap_next  = (step_next != 16'd1);
            end
            if (gap_next)
            begin
                gap_count_next = gap_count_reg + 32'd1;
            end
            prev_seq_next = frame_reg.frame_sequence;
            seq_seen_next = 1'b1;
        end
        else
        begin
            crc_fail_next = crc_fail_reg + 32'd1;
        end

        if (invalid)
        begin
            invalid_next = invalid_reg + 32'd1;
            if (run_reg != RUN_MAX)
            begin
                run_next = run_reg + 16'd1;
            end
            if (run_next > peak_reg)
            begin
                peak_next = run_next;
            end
        end
        else
        begin
            run_next      = 16'd0;
            accepted_next = accepted_reg + 32'd1;
            if (frame_reg.power_level >= power_thr_reg)
            begin
                power_seen_next = 1'b1;
            end
            else if (power_seen_reg && frame_reg.power_level == 16'sd0)
            begin
                drop_latch_next = 1'b1;
                drop_seq_next   = frame_reg.frame_sequence;
                drop_step_next  = step_next;
            end
        end

        priority if (!crc_ok)
        begin
            verdict_next = VERDICT_CRC;
        end
        else if (range_bad)
        begin
            verdict_next = VERDICT_RANGE;
        end
        else
        begin
            verdict_next = VERDICT_ACCEPT;
        end
    end

    // The tracking state doubles as the result register: it changes only when a
    // new result is loaded, so it always matches the result being offered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            verdict_reg    <= VERDICT_ACCEPT;
            step_reg       <= 16'd0;
            gap_reg        <= 1'b0;
            prev_seq_reg   <= 16'd0;
            seq_seen_reg   <= 1'b0;
            power_seen_reg <= 1'b0;
            drop_latch_reg <= 1'b0;
            drop_seq_reg   <= 16'd0;
            drop_step_reg  <= 16'd0;
            run_reg        <= 16'd0;
            peak_reg       <= 16'd0;
            accepted_reg   <= 32'd0;
            invalid_reg    <= 32'd0;
            crc_fail_reg   <= 32'd0;
            gap_count_reg  <= 32'd0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                verdict_reg    <= verdict_next;
                step_reg       <= step_next;
                gap_reg        <= gap_next;
                prev_seq_reg   <= prev_seq_next;
                seq_seen_reg   <= seq_seen_next;
                power_seen_reg <= power_seen_next;
                drop_latch_reg <= drop_latch_next;
                drop_seq_reg   <= drop_seq_next;
                drop_step_reg  <= drop_step_next;
                run_reg        <= run_next;
                peak_reg       <= peak_next;
                accepted_reg   <= accepted_next;
                invalid_reg    <= invalid_next;
                crc_fail_reg   <= crc_fail_next;
                gap_count_reg  <= gap_count_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tdata = {4'd0, gap_count_reg, crc_fail_reg, invalid_reg, accepted_reg,
                           peak_reg, run_reg, drop_step_reg, drop_seq_reg, drop_latch_reg,
                           gap_reg, step_reg, verdict_reg};

endmodule

/* rtl/core/tfc_checker.sv */
module tfc_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [tfc_pkg::OUT_W-1:0]   m_axis_tdata
);
    import tfc_pkg::*;

    logic [1:0]  verdict;
    logic [15:0] step;
    logic        gap;
    logic [15:0] run;
    logic [15:0] peak;

    assign verdict = m_axis_tdata[1:0];
    assign step    = m_axis_tdata[17:2];
    assign gap     = m_axis_tdata[18];
    assign run     = m_axis_tdata[67:52];
    assign peak    = m_axis_tdata[83:68];

    // A stalled result must hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A CRC failure leaves no sequence information in the result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && verdict == VERDICT_CRC |-> step == 16'd0 && !gap)
        else $error("sequence fields set on a CRC failure");

    // An accepted frame clears the invalid run; an invalid one leaves it nonzero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((verdict == VERDICT_ACCEPT) == (run == 16'd0)))
        else $error("invalid run does not match verdict");

    // The peak never falls below the current run.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> peak >= run)
        else $error("run peak below current run");

endmodule

bind telemetry_frame_checker tfc_checker u_tfc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
